@@ rtl/ivst_pkg.sv @@
// interrupt vector slot table: shared types, codes and defaults
// used by the top level and the port checker
`timescale 1ns / 1ps

package ivst_pkg;

  localparam int unsigned CPU_IRQS_DEF     = 64;
  localparam int unsigned VECTOR_SLOTS_DEF = 32;

  localparam int unsigned IRQ_NUM_W = 6;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned VSLOT_W   = 5;
  localparam int unsigned CMD_W     = 2;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned TDATA_W   = 72;

  typedef enum logic [CMD_W-1:0] {
    CMD_REGISTER = 2'd0,
    CMD_CLEAR    = 2'd1,
    CMD_DISPATCH = 2'd2,
    CMD_FINISH   = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_FAULT  = 2'd1,
    ST_LOCKED = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    FSM_IDLE    = 2'd0,
    FSM_SLOT_RD = 2'd1,
    FSM_EXEC    = 2'd2
  } fsm_e;

  // one word of the slot memory
  typedef struct packed {
    logic [IRQ_NUM_W-1:0] owner;
    logic [WORD_W-1:0]    handler;
    logic [WORD_W-1:0]    argument;
  } slot_entry_t;

endpackage

@@ rtl/ivst_free_find.sv @@
// interrupt vector slot table: finds the lowest slot that is not ready
// depends on nothing but its parameters
`timescale 1ns / 1ps

module ivst_free_find #(
  parameter int unsigned VECTOR_SLOTS = 32,
  parameter int unsigned SLOT_W       = 5
) (
  input  logic [VECTOR_SLOTS-1:0] ready_i,
  output logic                    found_o,
  output logic [SLOT_W-1:0]       slot_o
);

  always_comb begin
    found_o = 1'b0;
    slot_o  = '0;
    // walk downward so the lowest free slot wins
    for (int i = VECTOR_SLOTS - 1; i >= 0; i--) begin
      if (!ready_i[i]) begin
        found_o = 1'b1;
        slot_o  = SLOT_W'(i);
      end
    end
  end

endmodule

@@ rtl/interrupt_vector_slot_table.sv @@
// interrupt vector slot table top level: map memory, slot memory, control
// depends on ivst_pkg and ivst_free_find
`timescale 1ns / 1ps

// Maps interrupt numbers to a pool of vector slots.
// Input channel (s_axis): tuser carries the command (register, clear, dispatch,
// finish); tdata carries irq number, handler address, handler argument and the
// daemon request flag. Output channel (m_axis): tuser carries the status,
// tdata the call flag, call address, call argument, slot index and wake flag.
// Every item gives exactly one result item.
// An accepted item is handled in order: the accept edge reads the number-to-slot
// memory, the SLOT_RD state reads the slot memory, and the read-modify-write of
// the slot happens in the EXEC state at the edge that loads the result.
// A new item is taken at that same edge while the receiver keeps up, but none
// while the slot memory is read, as the two memory reads run in series.
// When the receiver stalls, the result waits in the output register, the
// update of the finished item is held back, and no new item is taken.
// Reset clears the mapped bits, the ready and locked bits and the output valid;
// the memories themselves are not cleared and need no clearing pass.
module interrupt_vector_slot_table #(
  parameter int unsigned CPU_IRQS     = ivst_pkg::CPU_IRQS_DEF,
  parameter int unsigned VECTOR_SLOTS = ivst_pkg::VECTOR_SLOTS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // irq_number, handler_address, handler_argument, daemon_request, zero pad
  input  logic [ivst_pkg::TDATA_W-1:0]    s_axis_tdata_i,
  // cmd
  input  logic [ivst_pkg::CMD_W-1:0]      s_axis_tuser_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // call_handler, call_address, call_argument, vector_slot, wake_daemon, zero pad
  output logic [ivst_pkg::TDATA_W-1:0]    m_axis_tdata_o,
  // status
  output logic [ivst_pkg::STATUS_W-1:0]   m_axis_tuser_o
);

  localparam int unsigned SLOT_W = (VECTOR_SLOTS > 1) ? $clog2(VECTOR_SLOTS) : 1;
  localparam int unsigned IRQ_W  = (CPU_IRQS > 1) ? $clog2(CPU_IRQS) : 1;
  localparam int unsigned NUM_W  = ivst_pkg::IRQ_NUM_W;
  localparam int unsigned WORD_W = ivst_pkg::WORD_W;

  // input unpacking
  logic [NUM_W-1:0]  in_irq;
  logic [WORD_W-1:0] in_addr;
  logic [WORD_W-1:0] in_arg;
  logic              in_dreq;
  logic              in_fire;

  assign in_irq  = s_axis_tdata_i[NUM_W-1:0];
  assign in_addr = s_axis_tdata_i[NUM_W+WORD_W-1:NUM_W];
  assign in_arg  = s_axis_tdata_i[NUM_W+2*WORD_W-1:NUM_W+WORD_W];
  assign in_dreq = s_axis_tdata_i[NUM_W+2*WORD_W];
  assign in_fire = s_axis_tvalid_i && s_axis_tready_o;

  // control
  ivst_pkg::fsm_e state_q, state_d;
  logic           exec_fire;

  // held item
  ivst_pkg::cmd_e    cmd_q;
  logic [NUM_W-1:0]  irq_q;
  logic [WORD_W-1:0] addr_q;
  logic [WORD_W-1:0] arg_q;
  logic              dreq_q;
  logic              in_range_q;

  // state storage
  logic [SLOT_W-1:0]         map_mem [CPU_IRQS];
  logic [SLOT_W-1:0]         map_rd_q;
  logic [CPU_IRQS-1:0]       mapped_q;
  ivst_pkg::slot_entry_t     slot_mem [VECTOR_SLOTS];
  ivst_pkg::slot_entry_t     slot_rd_q;
  logic [VECTOR_SLOTS-1:0]   ready_q;
  logic [VECTOR_SLOTS-1:0]   locked_q;

  // update controls
  logic                  map_we;
  logic                  map_set;
  logic                  map_clr;
  logic                  slot_we;
  logic [SLOT_W-1:0]     slot_waddr;
  ivst_pkg::slot_entry_t slot_wdata;
  logic                  ready_set;
  logic                  ready_clr;
  logic                  lock_set;
  logic                  lock_clr;
  logic [SLOT_W-1:0]     flag_idx;

  // result
  ivst_pkg::status_e status;
  logic              call;
  logic [WORD_W-1:0] caddr;
  logic [WORD_W-1:0] carg;
  logic [SLOT_W-1:0] vslot;
  logic              wake;

  logic                        out_valid_q;
  logic [ivst_pkg::TDATA_W-1:0] out_data_q;
  ivst_pkg::status_e           out_status_q;

  // lookup of the held item
  logic [IRQ_W-1:0]  irq_idx_q;
  logic [IRQ_W-1:0]  in_idx;
  logic              mapped;
  logic [SLOT_W-1:0] cur_slot;
  logic              cur_ready;
  logic              cur_locked;
  logic              owner_match;
  logic              free_found;
  logic              claim;
  logic [SLOT_W-1:0] free_slot;

  assign in_idx    = IRQ_W'(in_irq);
  assign irq_idx_q = IRQ_W'(irq_q);
  assign cur_slot  = map_rd_q;
  assign mapped    = in_range_q && mapped_q[irq_idx_q];
  assign cur_ready   = ready_q[cur_slot];
  assign cur_locked  = locked_q[cur_slot];
  assign owner_match = (slot_rd_q.owner == irq_q);

  ivst_free_find #(
    .VECTOR_SLOTS(VECTOR_SLOTS),
    .SLOT_W      (SLOT_W)
  ) u_free_find (
    .ready_i(ready_q),
    .found_o(free_found),
    .slot_o (free_slot)
  );

  assign exec_fire       = (state_q == ivst_pkg::FSM_EXEC) && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = (state_q == ivst_pkg::FSM_IDLE) || exec_fire;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ivst_pkg::FSM_IDLE: begin
        if (in_fire) state_d = ivst_pkg::FSM_SLOT_RD;
      end
      ivst_pkg::FSM_SLOT_RD: begin
        state_d = ivst_pkg::FSM_EXEC;
      end
      ivst_pkg::FSM_EXEC: begin
        if (exec_fire) state_d = in_fire ? ivst_pkg::FSM_SLOT_RD : ivst_pkg::FSM_IDLE;
      end
      default: state_d = ivst_pkg::FSM_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ivst_pkg::FSM_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // command evaluation and update controls
  always_comb begin
    status     = ivst_pkg::ST_FAULT;
    call       = 1'b0;
    caddr      = '0;
    carg       = '0;
    vslot      = '0;
    wake       = 1'b0;
    claim      = 1'b0;
    slot_we    = 1'b0;
    slot_waddr = cur_slot;
    slot_wdata = slot_rd_q;
    ready_set  = 1'b0;
    ready_clr  = 1'b0;
    lock_set   = 1'b0;
    lock_clr   = 1'b0;
    map_clr    = 1'b0;
    flag_idx   = cur_slot;
    unique case (cmd_q)
      ivst_pkg::CMD_REGISTER: begin
        if (mapped) begin
          vslot = cur_slot;
          if (cur_locked) begin
            status = ivst_pkg::ST_LOCKED;
          end else begin
            status              = ivst_pkg::ST_OK;
            slot_we             = 1'b1;
            slot_wdata.handler  = addr_q;
            slot_wdata.argument = arg_q;
          end
        end else if (in_range_q && free_found) begin
          claim      = 1'b1;
          status     = ivst_pkg::ST_OK;
          vslot      = free_slot;
          flag_idx   = free_slot;
          slot_we    = 1'b1;
          slot_waddr = free_slot;
          slot_wdata = '{owner: irq_q, handler: addr_q, argument: arg_q};
          ready_set  = 1'b1;
          lock_clr   = 1'b1;
        end
      end
      ivst_pkg::CMD_CLEAR: begin
        if (mapped && cur_ready && owner_match) begin
          vslot = cur_slot;
          if (cur_locked) begin
            status = ivst_pkg::ST_LOCKED;
          end else begin
            status     = ivst_pkg::ST_OK;
            map_clr    = 1'b1;
            slot_we    = 1'b1;
            slot_wdata = '0;
            ready_clr  = 1'b1;
            lock_clr   = 1'b1;
          end
        end
      end
      ivst_pkg::CMD_DISPATCH: begin
        if (mapped && cur_ready) begin
          vslot  = cur_slot;
          status = ivst_pkg::ST_OK;
          if (slot_rd_q.handler != '0) begin
            lock_set = 1'b1;
            call     = 1'b1;
            caddr    = slot_rd_q.handler;
            carg     = slot_rd_q.argument;
          end
        end
      end
      ivst_pkg::CMD_FINISH: begin
        if (mapped && cur_ready && cur_locked) begin
          vslot    = cur_slot;
          status   = ivst_pkg::ST_OK;
          lock_clr = 1'b1;
          wake     = dreq_q;
        end
      end
      default: status = ivst_pkg::ST_FAULT;
    endcase
  end

  assign map_we  = exec_fire && claim;
  assign map_set = exec_fire && claim;

  // held item registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q      <= ivst_pkg::cmd_e'(s_axis_tuser_i);
      irq_q      <= in_irq;
      addr_q     <= in_addr;
      arg_q      <= in_arg;
      dreq_q     <= in_dreq;
      in_range_q <= (32'(in_irq) < CPU_IRQS);
    end
  end

  // number-to-slot memory, a claim in the same edge is forwarded to the read
  always_ff @(posedge clk_i) begin
    if (map_we) begin
      map_mem[irq_idx_q] <= free_slot;
    end
    if (in_fire) begin
      map_rd_q <= (map_we && (irq_idx_q == in_idx)) ? free_slot : map_mem[in_idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mapped_q <= '0;
    end else if (exec_fire) begin
      if (map_set) mapped_q[irq_idx_q] <= 1'b1;
      if (map_clr) mapped_q[irq_idx_q] <= 1'b0;
    end
  end

  // slot memory
  always_ff @(posedge clk_i) begin
    if (exec_fire && slot_we) begin
      slot_mem[slot_waddr] <= slot_wdata;
    end
    if (state_q == ivst_pkg::FSM_SLOT_RD) begin
      slot_rd_q <= slot_mem[map_rd_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ready_q  <= '0;
      locked_q <= '0;
    end else if (exec_fire) begin
      if (ready_set) ready_q[flag_idx]  <= 1'b1;
      if (ready_clr) ready_q[flag_idx]  <= 1'b0;
      if (lock_set)  locked_q[flag_idx] <= 1'b1;
      if (lock_clr)  locked_q[flag_idx] <= 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (exec_fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec_fire) begin
      out_status_q <= status;
      out_data_q   <= {1'b0, wake, ivst_pkg::VSLOT_W'(vslot), carg, caddr, call};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_status_q;

endmodule

@@ rtl/ivst_checker.sv @@
// interrupt vector slot table: port checker and its bind to the top level
// depends on ivst_pkg and interrupt_vector_slot_table
`timescale 1ns / 1ps

module ivst_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid_i,
  input logic                          s_axis_tready_o,
  input logic                          m_axis_tvalid_o,
  input logic                          m_axis_tready_i,
  input logic [ivst_pkg::TDATA_W-1:0]  m_axis_tdata_o,
  input logic [ivst_pkg::STATUS_W-1:0] m_axis_tuser_o
);

  logic in_fire;
  logic out_call;
  logic out_wake;

  assign in_fire  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_call = m_axis_tdata_o[0];
  assign out_wake = m_axis_tdata_o[70];

  // a stalled result item holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o)
      && $stable(m_axis_tuser_o))
    else $error("stalled result item changed");

  // a call only comes with success and a non-null address
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && out_call |->
      m_axis_tuser_o == ivst_pkg::ST_OK && m_axis_tdata_o[32:1] != '0)
    else $error("call without success or with null address");

  // wake only on a successful finish, which never calls
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && out_wake |-> m_axis_tuser_o == ivst_pkg::ST_OK && !out_call)
    else $error("wake on a result that is not a finish");

  // status code three is never produced
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tuser_o == ivst_pkg::ST_OK
      || m_axis_tuser_o == ivst_pkg::ST_FAULT || m_axis_tuser_o == ivst_pkg::ST_LOCKED)
    else $error("undefined status code");

  // the slot memory read keeps the input closed for the cycle after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !s_axis_tready_o)
    else $error("input taken again right after an accept");

endmodule

bind interrupt_vector_slot_table ivst_checker u_ivst_checker (.*);
